>>> src/uim_pkg.sv
// ----------------------------------------------------------------------------
// uim_pkg: shared types and constants of the unique interval match block
// Beat formats of the input and result channels, command codes and the
// status bundle returned by the scan unit.
// ----------------------------------------------------------------------------
package uim_pkg;

  // Fixed widths of the beat fields.
  localparam int unsigned FieldBits = 32;
  localparam int unsigned IndexBits = 10;

  // Command codes. Code 3 is unused and ignored.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_LOAD  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  // Input beat.
  typedef struct packed {
    cmd_t                 command;
    logic [FieldBits-1:0] low_bound;
    logic [FieldBits-1:0] high_bound;
    logic [FieldBits-1:0] query_value;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic                 found;
    logic [IndexBits-1:0] entry_index;
    logic                 table_full;
  } out_beat_t;

  // Status from the scan unit to the sequencer.
  typedef struct packed {
    logic done;
    logic found;
  } scan_rsp_t;

endpackage

>>> src/uim_table.sv
// ----------------------------------------------------------------------------
// uim_table: interval bound storage
// Two memories, one for lower and one for upper bounds, with one write port
// and one registered read port shared by both.
// ----------------------------------------------------------------------------
module uim_table #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  parameter int unsigned IdxW  = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [Width-1:0] wr_low_i,
  input  logic [Width-1:0] wr_high_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [Width-1:0] rd_low_o,
  output logic [Width-1:0] rd_high_o
);

  logic [Width-1:0] low_mem  [Depth];
  logic [Width-1:0] high_mem [Depth];
  logic [Width-1:0] rd_low_q;
  logic [Width-1:0] rd_high_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      low_mem[wr_addr_i]  <= wr_low_i;
      high_mem[wr_addr_i] <= wr_high_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_low_q  <= low_mem[rd_addr_i];
      rd_high_q <= high_mem[rd_addr_i];
    end
  end

  assign rd_low_o  = rd_low_q;
  assign rd_high_o = rd_high_q;

endmodule

>>> src/uim_scan.sv
// ----------------------------------------------------------------------------
// uim_scan: sequential scan with one comparator pair
// Walks the stored entries one per cycle, compares each interval with the
// query value and keeps a match count saturating at two plus the last hit.
// ----------------------------------------------------------------------------
module uim_scan #(
  parameter int unsigned Width = 32,
  parameter int unsigned IdxW  = 10,
  parameter int unsigned CntW  = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [CntW-1:0]           count_i,
  input  logic [Width-1:0]          value_i,
  output logic                      rd_en_o,
  output logic [IdxW-1:0]           rd_addr_o,
  input  logic [Width-1:0]          rd_low_i,
  input  logic [Width-1:0]          rd_high_i,
  output uim_pkg::scan_rsp_t        rsp_o,
  output logic [IdxW-1:0]           index_o
);
  import uim_pkg::*;

  logic             act_q, act_d;
  logic [CntW-1:0]  addr_q, addr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] val_q, val_d;
  logic             pv_q, pv_d;
  logic             plast_q, plast_d;
  logic [IdxW-1:0]  pidx_q, pidx_d;
  logic [1:0]       match_q, match_d;
  logic [IdxW-1:0]  cand_q, cand_d;
  logic             hit;
  logic [CntW-1:0]  addr_inc;

  assign addr_inc  = addr_q + CntW'(1);
  assign rd_en_o   = act_q;
  assign rd_addr_o = addr_q[IdxW-1:0];

  // Compare stage on the registered read data.
  assign hit = pv_q && (rd_low_i <= val_q) && (val_q <= rd_high_i);

  always_comb begin
    act_d   = act_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    pv_d    = 1'b0;
    plast_d = 1'b0;
    pidx_d  = pidx_q;
    match_d = match_q;
    cand_d  = cand_q;

    // Accumulate the saturating match count and the latest candidate.
    if (hit) begin
      cand_d = pidx_q;
      if (match_q != 2'd2) begin
        match_d = match_q + 2'd1;
      end
    end

    // Address issue stage.
    if (start_i) begin
      act_d   = 1'b1;
      addr_d  = '0;
      cnt_d   = count_i;
      val_d   = value_i;
      match_d = 2'd0;
    end else if (act_q) begin
      pv_d   = 1'b1;
      pidx_d = addr_q[IdxW-1:0];
      addr_d = addr_inc;
      if (addr_inc == cnt_q) begin
        act_d   = 1'b0;
        plast_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      match_q <= 2'd0;
    end else begin
      act_q   <= act_d;
      pv_q    <= pv_d;
      plast_q <= plast_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    val_q  <= val_d;
    pidx_q <= pidx_d;
    cand_q <= cand_d;
  end

  // The final compare closes the scan; the result includes that entry.
  assign rsp_o.done  = pv_q && plast_q;
  assign rsp_o.found = (match_d == 2'd1);
  assign index_o     = cand_d;

endmodule

>>> src/unique_interval_match_core.sv
// ----------------------------------------------------------------------------
// unique_interval_match_core: interval table with unique-match query
// Loads closed intervals in order, clears the table, and answers stabbing
// queries with the load index of the single matching interval.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a command with its operands over valid/ready. A clear
//   empties the table and a load with room stores one interval; neither
//   gives a result beat. A load into a full table gives a beat with
//   table_full set. A query gives one beat: found with entry_index when
//   exactly one stored interval holds the value, found clear otherwise.
//   Clear and load leave ready high. A query reads the table memory one
//   entry per cycle through its single read port and compares each with
//   one comparator pair, for up to TABLE_ENTRIES stored entries; ready is
//   low meanwhile. A full-table load or a query on an empty table goes
//   straight to the result hand-off.
//   Results go to an output register. A stalled receiver does not block
//   clears or loads; a later result waits inside the block, with ready
//   low, until the output register frees up.
//   Reset empties the table at once; the memory contents are not cleared,
//   since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module unique_interval_match_core #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uim_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uim_pkg::out_beat_t  out_beat_o
);
  import uim_pkg::*;

  localparam int unsigned StoreBits = (VALUE_BITS < FieldBits) ? VALUE_BITS : FieldBits;
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  out_beat_t       res_q, res_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_q, out_d;

  logic            accept;
  logic            out_free;
  logic            table_is_full;
  logic            wr_en;
  logic            scan_start;
  scan_rsp_t       scan_rsp;
  logic [IdxW-1:0] scan_index;
  logic [IdxW-1:0] rd_addr;
  logic            rd_en;
  logic [StoreBits-1:0] rd_low;
  logic [StoreBits-1:0] rd_high;
  logic [IdxW+IndexBits-1:0] index_wide;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign accept        = in_valid_i && in_ready_o;
  assign out_free      = !out_valid_q || out_ready_i;
  assign table_is_full = (count_q == CntW'(TABLE_ENTRIES));
  assign index_wide    = {{IndexBits{1'b0}}, scan_index};

  // Sequencer: command decode, fill count and result hand-off.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    scan_start  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_beat_i.command)
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_LOAD: begin
              if (table_is_full) begin
                res_d.found       = 1'b0;
                res_d.entry_index = '0;
                res_d.table_full  = 1'b1;
                state_d           = ST_HOLD;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            CMD_QUERY: begin
              if (count_q == '0) begin
                res_d.found       = 1'b0;
                res_d.entry_index = '0;
                res_d.table_full  = 1'b0;
                state_d           = ST_HOLD;
              end else begin
                scan_start = 1'b1;
                state_d    = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          res_d.found       = scan_rsp.found;
          res_d.entry_index = scan_rsp.found ? index_wide[IndexBits-1:0] : '0;
          res_d.table_full  = 1'b0;
          state_d           = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Bound storage.
  uim_table #(
    .Depth (TABLE_ENTRIES),
    .Width (StoreBits),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_low_i  (in_beat_i.low_bound[StoreBits-1:0]),
    .wr_high_i (in_beat_i.high_bound[StoreBits-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_low_o  (rd_low),
    .rd_high_o (rd_high)
  );

  // Shared comparator scan.
  uim_scan #(
    .Width (StoreBits),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .count_i   (count_q),
    .value_i   (in_beat_i.query_value[StoreBits-1:0]),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_low_i  (rd_low),
    .rd_high_i (rd_high),
    .rsp_o     (scan_rsp),
    .index_o   (scan_index)
  );

endmodule

>>> tb/unique_interval_match_core_tb.sv
// ----------------------------------------------------------------------------
// unique_interval_match_core_tb: self-checking bench for the interval table
// Drives clear, load, query and unused beats under random backpressure on both
// channels, predicts each result beat from a behavioral copy of the table,
// and checks every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unique_interval_match_core_tb;
  import uim_pkg::*;

  localparam int TableDepth     = 1024;
  localparam int ValueBits      = 32;
  localparam int RandomBeats    = 555;
  localparam int SinkHoldCycles = 300;
  localparam int WatchdogLimit  = 8000;
  localparam int SettleCycles   = 1100;

  // The fourth command code has no function and must be ignored.
  localparam cmd_t CmdUnused = 2'd3;

  // One row of the directed stimulus, with a typed reply where one is fixed.
  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t reply;
  } plan_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  // Behavioral copy of the interval table.
  logic [FieldBits-1:0] model_lows  [TableDepth];
  logic [FieldBits-1:0] model_highs [TableDepth];
  int                   model_fill = 0;

  out_beat_t awaited_replies [$];
  plan_row_t directed_plan   [$];
  int        mismatch_count  = 0;
  int        beats_sent      = 0;
  int        idle_cycles     = 0;
  bit        no_gaps         = 1'b0;
  bit        sink_hold_req   = 1'b0;

  unique_interval_match_core #(
    .TABLE_ENTRIES (TableDepth),
    .VALUE_BITS    (ValueBits)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply one input beat to the table copy; returns 1 when it gives a result.
  function automatic bit match_reply(input in_beat_t beat, output out_beat_t reply);
    int hits;
    int hit_at;
    bit gives;
    reply  = '0;
    hits   = 0;
    hit_at = 0;
    gives  = 1'b0;
    case (beat.command)
      CMD_CLEAR: begin
        model_fill = 0;
      end
      CMD_LOAD: begin
        if (model_fill >= TableDepth) begin
          reply.table_full = 1'b1;
          gives = 1'b1;
        end else begin
          model_lows[model_fill]  = beat.low_bound;
          model_highs[model_fill] = beat.high_bound;
          model_fill++;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < model_fill; i++) begin
          if (model_lows[i] <= beat.query_value && beat.query_value <= model_highs[i]) begin
            hit_at = i;
            if (hits < 2) hits++;
          end
        end
        if (hits == 1) begin
          reply.found       = 1'b1;
          reply.entry_index = hit_at[IndexBits-1:0];
        end
        gives = 1'b1;
      end
      default: begin
      end
    endcase
    match_reply = gives;
  endfunction

  function automatic in_beat_t make_beat(input cmd_t cmd, input logic [FieldBits-1:0] lo,
                                         input logic [FieldBits-1:0] hi,
                                         input logic [FieldBits-1:0] probe);
    in_beat_t beat;
    beat.command     = cmd;
    beat.low_bound   = lo;
    beat.high_bound  = hi;
    beat.query_value = probe;
    return beat;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Random sender gap: mostly none, sometimes short, rarely long.
  task automatic take_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Offer one beat, hold it until accepted, then record its expected reply.
  task automatic drive_beat(input in_beat_t beat, input bit typed, input out_beat_t fixed_reply);
    out_beat_t reply;
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    if (match_reply(beat, reply)) begin
      awaited_replies = {awaited_replies, (typed ? fixed_reply : reply)};
    end
    if (beat.command != CmdUnused) beats_sent++;
    take_gap();
  endtask

  task automatic send(input cmd_t cmd, input logic [FieldBits-1:0] lo,
                      input logic [FieldBits-1:0] hi, input logic [FieldBits-1:0] probe);
    drive_beat(make_beat(cmd, lo, hi, probe), 1'b0, '0);
  endtask

  // Stop offering beats until every expected result has come back.
  task automatic wait_all_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_replies.size() != 0);
  endtask

  task automatic add_row(input cmd_t cmd, input logic [FieldBits-1:0] lo,
                         input logic [FieldBits-1:0] hi, input logic [FieldBits-1:0] probe,
                         input bit typed, input bit found, input int index, input bit full);
    plan_row_t row;
    row.beat                    = make_beat(cmd, lo, hi, probe);
    row.typed                   = typed;
    row.reply.found             = found;
    row.reply.entry_index       = index[IndexBits-1:0];
    row.reply.table_full        = full;
    directed_plan = {directed_plan, row};
  endtask

  // Extremes of the bounds, overlaps, a point interval, an empty interval,
  // the unused command and a query on an empty table.
  task automatic build_directed_plan();
    add_row(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0);
    add_row(CmdUnused, '1, '1, '1, 0, 0, 0, 0);
    add_row(CMD_LOAD, 0, '1, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 1, 1, 0, 0);
    add_row(CMD_QUERY, 0, 0, '1, 1, 1, 0, 0);
    add_row(CMD_LOAD, 10, 20, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 15, 1, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 21, 1, 1, 0, 0);
    add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 5, 1, 0, 0, 0);
    add_row(CMD_LOAD, 100, 200, 0, 0, 0, 0, 0);
    add_row(CMD_LOAD, 300, 300, 0, 0, 0, 0, 0);
    add_row(CMD_LOAD, 500, 400, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 99, 1, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 100, 1, 1, 0, 0);
    add_row(CMD_QUERY, 0, 0, 200, 1, 1, 0, 0);
    add_row(CMD_QUERY, 0, 0, 300, 1, 1, 1, 0);
    add_row(CMD_QUERY, 0, 0, 450, 1, 0, 0, 0);
    add_row(CMD_LOAD, '1, '1, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, '1, 1, 1, 3, 0);
    add_row(CMD_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
    add_row(CmdUnused, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0);
  endtask

  // Fill every entry with disjoint intervals, overflow it, and probe it.
  task automatic fill_to_capacity();
    out_beat_t overflow_reply;
    out_beat_t top_reply;
    logic [FieldBits-1:0] lo;
    int probe_at;
    overflow_reply            = '0;
    overflow_reply.table_full = 1'b1;
    top_reply                 = '0;
    top_reply.found           = 1'b1;
    top_reply.entry_index     = '1;
    send(CMD_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < TableDepth; i++) begin
      lo = {i[9:0], 22'd0} + $urandom_range(0, 1000);
      send(CMD_LOAD, lo, lo + $urandom_range(0, 2000000), $urandom);
    end
    drive_beat(make_beat(CMD_LOAD, $urandom, $urandom, $urandom), 1'b1, overflow_reply);
    drive_beat(make_beat(CMD_LOAD, 0, '1, $urandom), 1'b1, overflow_reply);
    drive_beat(make_beat(CMD_QUERY, $urandom, $urandom, model_lows[TableDepth-1]), 1'b1,
               top_reply);
    probe_at = $urandom_range(0, TableDepth - 1);
    send(CMD_QUERY, $urandom, $urandom, model_highs[0]);
    send(CMD_QUERY, $urandom, $urandom,
         model_lows[probe_at] + (model_highs[probe_at] - model_lows[probe_at]) / 2);
    send(CMD_QUERY, $urandom, $urandom, {probe_at[9:0], 22'h3F_FFFF});
    send(CMD_QUERY, $urandom, $urandom, 0);
    send(CMD_CLEAR, $urandom, $urandom, $urandom);
  endtask

  // Receiver stalls for a long stretch while queries keep coming, so the
  // block fills its result path and has to hold off the input.
  task automatic pressure_phase();
    wait_all_replies();
    no_gaps = 1'b1;
    send(CMD_CLEAR, $urandom, $urandom, $urandom);
    for (int j = 0; j < 6; j++) send(CMD_LOAD, j * 1000, j * 1000 + 500, $urandom);
    sink_hold_req = 1'b1;
    for (int j = 0; j < 12; j++) send(CMD_QUERY, $urandom, $urandom, $urandom_range(0, 6000));
    no_gaps = 1'b0;
  endtask

  // One random sequence: usually a clear, some loads, then queries aimed at
  // the loaded bounds, with stray unused commands mixed in.
  task automatic run_sequence();
    logic [FieldBits-1:0] lows  [48];
    logic [FieldBits-1:0] highs [48];
    logic [FieldBits-1:0] lo;
    logic [FieldBits-1:0] hi;
    logic [FieldBits-1:0] probe;
    int n_loads;
    int n_probes;
    int k;
    no_gaps = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0) send(CMD_CLEAR, $urandom, $urandom, $urandom);
    n_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    for (int j = 0; j < n_loads; j++) begin
      lo = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: hi = lo + $urandom_range(0, 1000);
        5, 6:          hi = lo + $urandom;
        7, 8: begin
          if (j > 0) begin
            k  = $urandom_range(0, j - 1);
            lo = lows[k] + $urandom_range(0, 50);
            hi = highs[k];
          end else begin
            hi = lo + $urandom_range(0, 100);
          end
        end
        default:       hi = lo - 1 - $urandom_range(0, 100);
      endcase
      if ($urandom_range(0, 9) < 7 && hi < lo && lo - hi > 200) hi = '1;
      lows[j]  = lo;
      highs[j] = hi;
      send(CMD_LOAD, lo, hi, $urandom);
      if ($urandom_range(0, 19) == 0) send(CmdUnused, $urandom, $urandom, $urandom);
    end
    n_probes = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 8);
    for (int j = 0; j < n_probes; j++) begin
      if (n_loads > 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, n_loads - 1);
        case ($urandom_range(0, 5))
          0:       probe = lows[k];
          1:       probe = highs[k];
          2:       probe = lows[k] - 1;
          3:       probe = highs[k] + 1;
          4:       probe = lows[k] + (highs[k] - lows[k]) / 2;
          default: probe = lows[k] + $urandom_range(0, 64);
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       probe = '0;
          1:       probe = '1;
          default: probe = $urandom;
        endcase
      end
      send(CMD_QUERY, $urandom, $urandom, probe);
      if ($urandom_range(0, 19) == 0) send(CmdUnused, $urandom, $urandom, $urandom);
    end
    no_gaps = 1'b0;
  endtask

  // Result receiver: stretches of steady ready, random stalls, and one long
  // hold when the stimulus asks for it.
  initial begin : drive_sink
    int  run_len;
    bit  level;
    run_len = 0;
    level   = 1'b1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk_i);
        sink_hold_req = 1'b0;
        run_len       = 0;
      end
      if (run_len == 0) begin
        level = ($urandom_range(0, 99) < 55);
        if (level) run_len = $urandom_range(1, 40);
        else if ($urandom_range(0, 99) < 85) run_len = $urandom_range(1, 3);
        else run_len = $urandom_range(10, 50);
      end
      out_ready_i <= level;
      run_len--;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_replies
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch($sformatf("result beat %p with no result expected", out_beat_o));
      end else begin
        want = awaited_replies.pop_front();
        if (out_beat_o.found !== want.found)
          flag_mismatch($sformatf("found %0b, expected %0b", out_beat_o.found, want.found));
        if (out_beat_o.entry_index !== want.entry_index)
          flag_mismatch($sformatf("entry_index %0d, expected %0d",
                                  out_beat_o.entry_index, want.entry_index));
        if (out_beat_o.table_full !== want.table_full)
          flag_mismatch($sformatf("table_full %0b, expected %0b",
                                  out_beat_o.table_full, want.table_full));
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Main stimulus: reset, directed rows, a full table, then random sequences.
  initial begin : run_stimulus
    int  base;
    bit  pressure_done;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_directed_plan();
    for (int i = 0; i < directed_plan.size(); i++)
      drive_beat(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].reply);

    fill_to_capacity();

    base = beats_sent;
    while (beats_sent - base < RandomBeats) begin
      if (!pressure_done && beats_sent - base >= RandomBeats / 2) begin
        pressure_phase();
        wait_all_replies();
        pressure_done = 1'b1;
      end
      run_sequence();
      if ($urandom_range(0, 7) == 0) wait_all_replies();
    end

    // Drain, then give any stray beat time to show up.
    wait_all_replies();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
